// ----- design/cilp_pkg.sv -----
// ----------------------------------------------------------------------------
// cilp_pkg
// Types and constants shared by the C integer literal parser modules.
// ----------------------------------------------------------------------------
package cilp_pkg;

   // Parser phase, one-hot.
   typedef enum logic [5:0] {
      PH_START  = 6'b000001,
      PH_ZERO   = 6'b000010,
      PH_HEXPFX = 6'b000100,
      PH_DIGITS = 6'b001000,
      PH_SUFFIX = 6'b010000,
      PH_FAULT  = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_DIGIT  = 3'd1,
      ERR_OVF    = 3'd2,
      ERR_JUNK   = 3'd3,
      ERR_NOTYPE = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_LOWER = 2'd1,
      PEND_UPPER = 2'd2
   } pend_type;

   typedef enum logic {
      CSR_INT_WIDTH  = 1'b0,
      CSR_LONG_WIDTH = 1'b1
   } csr_index_type;

   // Suffix flag bits.
   localparam logic [2:0] SF_U  = 3'b001;
   localparam logic [2:0] SF_L  = 3'b010;
   localparam logic [2:0] SF_LL = 3'b100;

   // Result type codes.
   localparam logic [2:0] TY_INT   = 3'd0;
   localparam logic [2:0] TY_UINT  = 3'd1;
   localparam logic [2:0] TY_LONG  = 3'd2;
   localparam logic [2:0] TY_ULONG = 3'd3;
   localparam logic [2:0] TY_LL    = 3'd4;
   localparam logic [2:0] TY_ULL   = 3'd5;

   localparam logic [5:0] INT_WIDTH_RESET  = 6'd32;
   localparam logic [6:0] LONG_WIDTH_RESET = 7'd64;

   typedef struct packed {
      phase_type  phase;
      radix_type  radix;
      logic [63:0] acc;
      logic [2:0] suffix;
      pend_type   pending;
      err_type    err;
   } token_type;

   localparam token_type TOKEN_RESET = '{
      phase:   PH_START,
      radix:   RX_DEC,
      acc:     64'd0,
      suffix:  3'b000,
      pending: PEND_NONE,
      err:     ERR_OK
   };

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  type_code;
      err_type     err;
   } result_type;

endpackage

// ----- design/cilp_step.sv -----
// ----------------------------------------------------------------------------
// cilp_step
// Advances the token state by one character: prefix, digit and suffix rules.
// ----------------------------------------------------------------------------
module cilp_step (
   input  cilp_pkg::token_type cur,
   input  logic [7:0]          char_code,
   output cilp_pkg::token_type nxt
);
   import cilp_pkg::*;

   logic [4:0]  digit;
   logic [4:0]  base;
   logic [67:0] prod;
   logic [67:0] sum;
   logic        run_digit;
   logic        run_suffix;
   logic        skip;
   logic [7:0]  same;

   // Digit value 0..15, or 16 when the character is no digit at all.
   always_comb begin
      if (char_code >= "0" && char_code <= "9") begin
         digit = 5'(char_code - "0");
      end else if (char_code >= "a" && char_code <= "f") begin
         digit = 5'(char_code - "a" + 8'd10);
      end else if (char_code >= "A" && char_code <= "F") begin
         digit = 5'(char_code - "A" + 8'd10);
      end else begin
         digit = 5'd16;
      end
   end

   // Constant-base multiply as shifts; the top four bits catch a carry past 64 bits.
   always_comb begin
      case (cur.radix)
         RX_OCT: begin
            base = 5'd8;
            prod = {4'd0, cur.acc} << 3;
         end
         RX_HEX: begin
            base = 5'd16;
            prod = {4'd0, cur.acc} << 4;
         end
         default: begin
            base = 5'd10;
            prod = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1);
         end
      endcase
      sum = prod + {63'd0, digit};
   end

   always_comb begin
      nxt        = cur;
      run_digit  = 1'b0;
      run_suffix = 1'b0;
      skip       = 1'b0;
      same       = "l";

      case (cur.phase)
         PH_START: begin
            if (char_code == "0") begin
               nxt.radix = RX_OCT;
               nxt.acc   = 64'd0;
               nxt.phase = PH_ZERO;
            end else if (char_code >= "1" && char_code <= "9") begin
               nxt.radix = RX_DEC;
               nxt.acc   = {56'd0, char_code - "0"};
               nxt.phase = PH_DIGITS;
            end else begin
               nxt.err   = ERR_DIGIT;
               nxt.phase = PH_FAULT;
            end
         end
         PH_ZERO: begin
            if (char_code == "x" || char_code == "X") begin
               nxt.radix = RX_HEX;
               nxt.phase = PH_HEXPFX;
            end else begin
               run_digit = 1'b1;
            end
         end
         PH_HEXPFX: begin
            if (digit != 5'd16) begin
               run_digit = 1'b1;
            end else begin
               nxt.err   = ERR_DIGIT;
               nxt.phase = PH_FAULT;
            end
         end
         PH_DIGITS: begin
            run_digit = 1'b1;
         end
         PH_SUFFIX: begin
            if (digit != 5'd16) begin
               nxt.err   = ERR_JUNK;
               nxt.phase = PH_FAULT;
            end else begin
               run_suffix = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (run_digit) begin
         if (digit == 5'd16) begin
            nxt.phase  = PH_SUFFIX;
            run_suffix = 1'b1;
         end else if (digit >= base) begin
            nxt.err   = ERR_DIGIT;
            nxt.phase = PH_FAULT;
         end else if (sum[67:64] != 4'd0) begin
            nxt.err   = ERR_OVF;
            nxt.phase = PH_FAULT;
         end else begin
            nxt.acc   = sum[63:0];
            nxt.phase = PH_DIGITS;
         end
      end

      if (run_suffix) begin
         // A waiting l either pairs with a matching l into ll, or stands alone.
         if (nxt.pending != PEND_NONE) begin
            same        = (nxt.pending == PEND_LOWER) ? "l" : "L";
            nxt.pending = PEND_NONE;
            if (char_code == same) begin
               nxt.suffix = nxt.suffix | SF_LL;
               skip       = 1'b1;
            end else begin
               nxt.suffix = nxt.suffix | SF_L;
            end
         end
         if (!skip) begin
            if (char_code == "u" || char_code == "U") begin
               if ((nxt.suffix & SF_U) != 3'b000) begin
                  nxt.err   = ERR_JUNK;
                  nxt.phase = PH_FAULT;
               end else begin
                  nxt.suffix = nxt.suffix | SF_U;
               end
            end else if (char_code == "l" || char_code == "L") begin
               if ((nxt.suffix & (SF_L | SF_LL)) != 3'b000) begin
                  nxt.err   = ERR_JUNK;
                  nxt.phase = PH_FAULT;
               end else begin
                  nxt.pending = (char_code == "l") ? PEND_LOWER : PEND_UPPER;
               end
            end else begin
               nxt.err   = ERR_JUNK;
               nxt.phase = PH_FAULT;
            end
         end
      end
   end

endmodule

// ----- design/cilp_result.sv -----
// ----------------------------------------------------------------------------
// cilp_result
// Closes a token: final error check and choice of the smallest fitting type.
// ----------------------------------------------------------------------------
module cilp_result (
   input  cilp_pkg::token_type  tok,
   input  logic [5:0]           int_width,
   input  logic [6:0]           long_width,
   output cilp_pkg::result_type res
);
   import cilp_pkg::*;

   logic [6:0] iw;
   logic [6:0] lw;
   logic [2:0] flags;
   logic       sgn_ok;
   logic       uns_ok;
   logic       has_l;
   logic       has_ll;
   logic       found;
   logic [2:0] ty;
   err_type    err;

   // True when v fits in w unsigned bits.
   function automatic logic fits(input logic [63:0] v, input logic [6:0] w);
      return (w >= 7'd64) ? 1'b1 : ((v >> w) == 64'd0);
   endfunction

   always_comb begin
      // Widths are clamped into their legal ranges.
      if (int_width < 6'd16) begin
         iw = 7'd16;
      end else if (int_width > 6'd32) begin
         iw = 7'd32;
      end else begin
         iw = {1'b0, int_width};
      end
      if (long_width < 7'd32) begin
         lw = 7'd32;
      end else if (long_width > 7'd64) begin
         lw = 7'd64;
      end else begin
         lw = long_width;
      end

      flags  = tok.suffix | ((tok.pending != PEND_NONE) ? SF_L : 3'b000);
      sgn_ok = (flags & SF_U) == 3'b000;
      uns_ok = !sgn_ok || (tok.radix != RX_DEC);
      has_l  = (flags & SF_L) != 3'b000;
      has_ll = (flags & SF_LL) != 3'b000;

      found = 1'b1;
      if (!has_l && !has_ll && sgn_ok && fits(tok.acc, iw - 7'd1)) begin
         ty = TY_INT;
      end else if (!has_l && !has_ll && uns_ok && fits(tok.acc, iw)) begin
         ty = TY_UINT;
      end else if (!has_ll && sgn_ok && fits(tok.acc, lw - 7'd1)) begin
         ty = TY_LONG;
      end else if (!has_ll && uns_ok && fits(tok.acc, lw)) begin
         ty = TY_ULONG;
      end else if (sgn_ok && !tok.acc[63]) begin
         ty = TY_LL;
      end else if (uns_ok) begin
         ty = TY_ULL;
      end else begin
         ty    = TY_INT;
         found = 1'b0;
      end

      err = tok.err;
      if (err == ERR_OK && tok.phase == PH_HEXPFX) begin
         err = ERR_DIGIT;
      end
      if (err == ERR_OK && !found) begin
         err = ERR_NOTYPE;
      end

      res.err = err;
      if (err == ERR_OK) begin
         res.value     = tok.acc;
         res.type_code = ty;
      end else begin
         res.value     = 64'd0;
         res.type_code = TY_INT;
      end
   end

endmodule

// ----- design/c_integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// c_integer_literal_parser
// Parses C integer constants one character per beat and returns the value,
// its C type and an error code on the last character of each token.
// ----------------------------------------------------------------------------
//
//   Port group  Dir  Payload                                   Beat
//   req_        in   tdata[7:0] char_code, tlast last_char     one character
//   rsp_        out  tdata[63:0] literal_value,                one per token
//                    tuser[2:0] type_code, tuser[5:3] error_code
//   csr_        in   index 0 int_width, 1 long_width, data     one register
//
// One character is taken every cycle while no last character is stalled. A
// character is registered, then the next-state and type logic runs into the
// result register, which is loaded when the token's last character moves on
// out of the character register.
// Reset clears the token state and sets int_width to 32 and long_width to 64.
// When a result is held by rsp_tready low, a last character waiting behind it
// stalls; characters that are not last keep flowing.
// ----------------------------------------------------------------------------
module c_integer_literal_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] literal_value
   output logic [5:0]  rsp_tuser,   // [2:0] type_code, [5:3] error_code
   input  logic        csr_valid,
   output logic        csr_ready,
   input  cilp_pkg::csr_index_type csr_index,
   input  logic [6:0]  csr_data
);
   import cilp_pkg::*;

   logic [5:0] iw_ff, iw_in;
   logic [6:0] lw_ff, lw_in;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff, s1_char_in;
   logic       s1_last_ff, s1_last_in;

   token_type  tok_ff, tok_in;
   token_type  tok_step;
   result_type res;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        advance;

   cilp_step u_step (
      .cur       (tok_ff),
      .char_code (s1_char_ff),
      .nxt       (tok_step)
   );

   cilp_result u_result (
      .tok        (tok_step),
      .int_width  (iw_ff),
      .long_width (lw_ff),
      .res        (res)
   );

   // A last character moves on only when the result register can take it.
   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      iw_in = iw_ff;
      lw_in = lw_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INT_WIDTH:  iw_in = csr_data[5:0];
            CSR_LONG_WIDTH: lw_in = csr_data;
            default: begin
            end
         endcase
      end

      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      s1_last_in  = s1_last_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_char_in  = req_tdata;
         s1_last_in  = req_tlast;
      end

      tok_in = tok_ff;
      if (advance) begin
         tok_in = s1_last_ff ? TOKEN_RESET : tok_step;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff        <= INT_WIDTH_RESET;
         lw_ff        <= LONG_WIDTH_RESET;
         s1_valid_ff  <= 1'b0;
         tok_ff       <= TOKEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         iw_ff        <= iw_in;
         lw_ff        <= lw_in;
         s1_valid_ff  <= s1_valid_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff <= s1_char_in;
      s1_last_ff <= s1_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = {rsp_ff.err, rsp_ff.type_code};

endmodule

// ----- tb/c_integer_literal_parser_test.sv -----
// ----------------------------------------------------------------------------
// c_integer_literal_parser_test
// Streams C integer constant tokens into the parser one character per beat.
// A scoreboard model tracks the token state and the width registers; every
// result beat is checked against it or against a table row's result. A
// short table of hand-picked tokens runs first, then random tokens under
// several register settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module c_integer_literal_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cilp_pkg::*;

   localparam int IDLE_CYCLES  = 4;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_CHARS  = 50;
   localparam int PHASE_COUNT  = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] char_code
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] literal_value
   logic [5:0]  rsp_tuser;           // [2:0] type_code, [5:3] error_code
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_index_type csr_index = CSR_INT_WIDTH;
   logic [6:0]  csr_data = 7'd0;

   c_integer_literal_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[c_integer_literal_parser] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Scoreboard model of the token parser
   // ------------------------------------------------------------------
   phase_type   lit_phase;
   radix_type   lit_radix;
   logic [63:0] lit_acc;
   logic [2:0]  lit_suffix;
   pend_type    lit_pend;
   err_type     lit_err;
   logic [5:0]  int_width_reg;
   logic [6:0]  long_width_reg;

   result_type  pending_literals[$];
   int unsigned mismatch_count = 0;

   function automatic logic [4:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return 5'd16;
   endfunction

   function automatic void clear_token();
      lit_phase  = PH_START;
      lit_radix  = RX_DEC;
      lit_acc    = 64'd0;
      lit_suffix = 3'b000;
      lit_pend   = PEND_NONE;
      lit_err    = ERR_OK;
   endfunction

   function automatic void fault(err_type e);
      lit_err   = e;
      lit_phase = PH_FAULT;
   endfunction

   function automatic void scan_suffix(logic [7:0] c);
      logic [7:0] same;
      // A single l waits one character to see whether it doubles to ll.
      if (lit_pend != PEND_NONE) begin
         same = (lit_pend == PEND_LOWER) ? "l" : "L";
         lit_pend = PEND_NONE;
         if (c == same) begin
            lit_suffix |= SF_LL;
            return;
         end
         lit_suffix |= SF_L;
      end
      if (c == "u" || c == "U") begin
         if ((lit_suffix & SF_U) != 0) fault(ERR_JUNK);
         else lit_suffix |= SF_U;
      end else if (c == "l" || c == "L") begin
         if ((lit_suffix & (SF_L | SF_LL)) != 0) fault(ERR_JUNK);
         else lit_pend = (c == "l") ? PEND_LOWER : PEND_UPPER;
      end else begin
         fault(ERR_JUNK);
      end
   endfunction

   function automatic void scan_digit(logic [7:0] c);
      logic [4:0]  d;
      logic [63:0] base;
      d = digit_value(c);
      base = (lit_radix == RX_OCT) ? 64'd8 : (lit_radix == RX_HEX) ? 64'd16 : 64'd10;
      if (d == 5'd16) begin
         lit_phase = PH_SUFFIX;
         scan_suffix(c);
      end else if (64'(d) >= base) begin
         fault(ERR_DIGIT);
      end else if (lit_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
         fault(ERR_OVF);
      end else begin
         lit_acc   = lit_acc * base + 64'(d);
         lit_phase = PH_DIGITS;
      end
   endfunction

   function automatic void parse_char(logic [7:0] c);
      case (lit_phase)
         PH_START: begin
            if (c == "0") begin
               lit_radix = RX_OCT;
               lit_acc   = 64'd0;
               lit_phase = PH_ZERO;
            end else if (c >= "1" && c <= "9") begin
               lit_radix = RX_DEC;
               lit_acc   = 64'(c - "0");
               lit_phase = PH_DIGITS;
            end else begin
               fault(ERR_DIGIT);
            end
         end
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               lit_radix = RX_HEX;
               lit_phase = PH_HEXPFX;
            end else begin
               scan_digit(c);
            end
         end
         PH_HEXPFX: begin
            if (digit_value(c) != 5'd16) scan_digit(c);
            else fault(ERR_DIGIT);
         end
         PH_DIGITS: scan_digit(c);
         PH_SUFFIX: begin
            if (digit_value(c) != 5'd16) fault(ERR_JUNK);
            else scan_suffix(c);
         end
         default: ;
      endcase
   endfunction

   function automatic logic [63:0] width_max(int w);
      return (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << w) - 64'd1;
   endfunction

   // Returns TY_ULL + 1 when no type can hold the value.
   function automatic int smallest_type();
      int iw;
      int lw;
      bit sgn_ok;
      bit uns_ok;
      bit has_l;
      bit has_ll;
      iw = (int_width_reg < 16) ? 16 : (int_width_reg > 32) ? 32 : int'(int_width_reg);
      lw = (long_width_reg < 32) ? 32 : (long_width_reg > 64) ? 64 : int'(long_width_reg);
      sgn_ok = (lit_suffix & SF_U) == 0;
      uns_ok = !sgn_ok || lit_radix != RX_DEC;
      has_l  = (lit_suffix & SF_L) != 0;
      has_ll = (lit_suffix & SF_LL) != 0;
      if (!has_l && !has_ll) begin
         if (sgn_ok && lit_acc <= width_max(iw - 1)) return TY_INT;
         if (uns_ok && lit_acc <= width_max(iw)) return TY_UINT;
      end
      if (!has_ll) begin
         if (sgn_ok && lit_acc <= width_max(lw - 1)) return TY_LONG;
         if (uns_ok && lit_acc <= width_max(lw)) return TY_ULONG;
      end
      if (sgn_ok && lit_acc <= width_max(63)) return TY_LL;
      if (uns_ok) return TY_ULL;
      return TY_ULL + 1;
   endfunction

   function automatic result_type finish_literal();
      result_type r;
      err_type    e;
      int         ty;
      e  = lit_err;
      ty = TY_INT;
      if (e == ERR_OK && lit_phase == PH_HEXPFX) e = ERR_DIGIT;
      if (e == ERR_OK) begin
         if (lit_pend != PEND_NONE) begin
            lit_suffix |= SF_L;
            lit_pend = PEND_NONE;
         end
         ty = smallest_type();
         if (ty > TY_ULL) e = ERR_NOTYPE;
      end
      r.err = e;
      if (e != ERR_OK) begin
         r.value     = 64'd0;
         r.type_code = TY_INT;
      end else begin
         r.value     = lit_acc;
         r.type_code = 3'(ty);
      end
      clear_token();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_literals.size() == 0) begin
            $error("result beat with none pending: literal_value %0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_literals.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("literal_value: expected %0h, actual %0h", want.value, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[2:0] !== want.type_code) begin
               $error("type_code: expected %0d, actual %0d", want.type_code, rsp_tuser[2:0]);
               mismatch_count++;
            end
            if (rsp_tuser[5:3] !== want.err) begin
               $error("error_code: expected %0d, actual %0d", want.err, rsp_tuser[5:3]);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern that changes every so often, plus a long
   // hold-off on request.
   // ------------------------------------------------------------------
   int unsigned hold_req = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned pattern_left = 0;
   int unsigned stall_pct = 0;

   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(20, 200);
            stall_pct    <= ($urandom_range(0, 4) < 2) ? 0 : 30 * $urandom_range(1, 3);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   int unsigned burst_left = 0;
   bit          allow_gaps = 1'b1;
   bit          gappy = 1'b0;
   logic [7:0]  token_chars[$];
   int unsigned chars_sent = 0;

   task automatic send_char(logic [7:0] c, logic is_last);
      int unsigned idle;
      if (burst_left == 0) begin
         idle = (allow_gaps && gappy) ? $urandom_range(0, 6) : 0;
         if (idle != 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
         gappy = $urandom_range(0, 3) != 0;
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_char(c);
      if (is_last) pending_literals.push_back(finish_literal());
      chars_sent++;
   endtask

   task automatic send_token();
      for (int i = 0; i < token_chars.size(); i++)
         send_char(token_chars[i], i == token_chars.size() - 1);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_literals.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_widths(logic [6:0] iw, logic [6:0] lw);
      csr_valid <= 1'b1;
      csr_index <= CSR_INT_WIDTH;
      csr_data  <= iw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      int_width_reg = iw[5:0];
      csr_index <= CSR_LONG_WIDTH;
      csr_data  <= lw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      long_width_reg = lw;
      csr_valid <= 1'b0;
   endtask

   string suffix_pool[] = '{"", "", "", "u", "U", "l", "L", "ll", "LL", "ul", "Lu",
                            "uLL", "llU", "lL", "uu", "lll", "Ll"};
   string junk_pool = "89aAfFgGxXuUlL .+-_";

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
   endfunction

   // Mostly well-formed constants, some near the type boundaries, with some
   // corrupted ones and some raw byte noise.
   function automatic void build_token();
      logic [63:0] v;
      logic [7:0]  c;
      string       digits;
      int unsigned pick;
      int unsigned w;
      int unsigned rsel;
      token_chars.delete();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 4)) token_chars.push_back(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 3))
         0: v = 64'($urandom_range(0, 99));
         1: begin
            w = $urandom_range(15, 64);
            v = ((w == 64) ? 64'd0 : (64'd1 << w)) + 64'($urandom_range(0, 3)) - 64'd2;
         end
         2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = {$urandom, $urandom};
      endcase
      rsel = $urandom_range(0, 2);
      if (rsel == 0) begin
         digits = $sformatf("%0d", v);
      end else if (rsel == 1) begin
         digits = {"0", $sformatf("%0o", v)};
      end else begin
         if ($urandom_range(0, 1) != 0) push_text("0x");
         else push_text("0X");
         if ($urandom_range(0, 7) == 0) push_text("00");
         digits = $sformatf("%0h", v);
      end
      for (int i = 0; i < digits.len(); i++) begin
         c = digits[i];
         if (c >= "a" && c <= "f" && $urandom_range(0, 1) != 0) c = c - 8'd32;
         token_chars.push_back(c);
      end
      // One more digit sometimes carries a large value past 64 bits.
      if ($urandom_range(0, 11) == 0)
         token_chars.push_back(8'("0" + $urandom_range(0, (rsel == 1) ? 7 : 9)));
      push_text(suffix_pool[$urandom_range(0, suffix_pool.size() - 1)]);
      if (pick < 22)
         token_chars[$urandom_range(0, token_chars.size() - 1)] =
            junk_pool[$urandom_range(0, junk_pool.len() - 1)];
   endfunction

   // ------------------------------------------------------------------
   // Directed tokens
   // ------------------------------------------------------------------
   typedef struct {
      string      text;
      bit         known;
      result_type want;
   } literal_row_type;

   literal_row_type directed_rows[] = '{
      '{"0",                   1'b1, '{64'd0, TY_INT, ERR_OK}},
      '{"\377",                1'b1, '{64'd0, TY_INT, ERR_DIGIT}},
      '{"08",                  1'b1, '{64'd0, TY_INT, ERR_DIGIT}},
      '{"1a",                  1'b1, '{64'd0, TY_INT, ERR_DIGIT}},
      '{"0x",                  1'b1, '{64'd0, TY_INT, ERR_DIGIT}},
      '{"0777",                1'b0, '0},
      '{"0XfF",                1'b0, '0},
      '{"7u",                  1'b0, '0},
      '{"5l",                  1'b0, '0},
      '{"5ul",                 1'b0, '0},
      '{"5LL",                 1'b0, '0},
      '{"5llu",                1'b0, '0},
      '{"5lL",                 1'b1, '{64'd0, TY_INT, ERR_JUNK}},
      '{"5uu",                 1'b1, '{64'd0, TY_INT, ERR_JUNK}},
      '{"5u7",                 1'b1, '{64'd0, TY_INT, ERR_JUNK}},
      '{"0x10000000000000000", 1'b1, '{64'd0, TY_INT, ERR_OVF}},
      '{"9223372036854775808", 1'b1, '{64'd0, TY_INT, ERR_NOTYPE}}
   };

   initial begin
      logic [6:0] phase_iw[PHASE_COUNT];
      logic [6:0] phase_lw[PHASE_COUNT];
      int unsigned phase_end;

      clear_token();
      int_width_reg  = INT_WIDTH_RESET;
      long_width_reg = LONG_WIDTH_RESET;
      phase_iw = '{7'd16, 7'h40, 7'd63, 7'($urandom_range(0, 63)), 7'd32};
      phase_lw = '{7'd32, 7'd127, 7'd0, 7'($urandom_range(0, 127)), 7'd64};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         token_chars.delete();
         push_text(directed_rows[r].text);
         send_token();
         if (directed_rows[r].known)
            pending_literals[pending_literals.size() - 1] = directed_rows[r].want;
      end
      settle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_widths(phase_iw[p], phase_lw[p]);
         if (p == 0) begin
            // Hold the result side off while characters keep coming.
            hold_req <= hold_req + 1;
            allow_gaps = 1'b0;
            repeat (8) begin
               build_token();
               send_token();
            end
            allow_gaps = 1'b1;
         end
         phase_end = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) begin
            build_token();
            send_token();
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[c_integer_literal_parser] OK");
      end else begin
         $display("[c_integer_literal_parser] ERROR");
      end
      $finish;
   end

endmodule
